// ===== sv/rgb_led_matrix_pwm_refresh_core_defines.svh =====
// Assertion macros for the LED matrix refresh core checker.
// Needs clk and arst_n in scope where a macro is used.
`ifndef RGB_LED_MATRIX_PWM_REFRESH_CORE_DEFINES_SVH
`define RGB_LED_MATRIX_PWM_REFRESH_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RLM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("refresh core check failed");

// next-cycle implication, checked outside reset
`define RLM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("refresh core check failed");

`endif

// ===== sv/rlm_pkg.sv =====
// Shared types, codes, palette and LED placement for the LED matrix refresh core.
// No dependencies.
package rlm_pkg;

	localparam int LED_COUNT_DEF = 27;
	localparam int PALETTE_SIZE  = 16;
	localparam int NUM_COLS      = 9;
	localparam int NUM_GROUPS    = 3;
	localparam int LAST_COL      = 8;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	localparam logic REG_MAX_LEVEL = 1'b0;
	localparam logic REG_PWM_STEP  = 1'b1;

	// one group entry: red [5:0], green [11:6], blue [17:12]
	typedef logic [17:0] rgb_t;

	typedef struct packed {
		logic       wr;
		logic       clr;
		logic [3:0] col;
		logic [1:0] grp;
		rgb_t       rgb;
	} store_cmd_t;

	typedef struct packed {
		logic [3:0] col;
		logic [1:0] grp;
	} place_t;

	function automatic rgb_t palette(input logic [3:0] code);
		rgb_t v;
		case (code)
			4'd0:    v = {6'd0,  6'd0,  6'd30};
			4'd1:    v = {6'd0,  6'd25, 6'd0};
			4'd2:    v = {6'd25, 6'd0,  6'd0};
			4'd3:    v = {6'd0,  6'd50, 6'd50};
			4'd4:    v = {6'd5,  6'd15, 6'd0};
			4'd5:    v = {6'd25, 6'd0,  6'd30};
			4'd6:    v = {6'd2,  6'd7,  6'd50};
			4'd7:    v = {6'd50, 6'd50, 6'd50};
			4'd8:    v = {6'd0,  6'd0,  6'd10};
			4'd9:    v = {6'd0,  6'd20, 6'd0};
			4'd10:   v = {6'd8,  6'd0,  6'd0};
			4'd11:   v = {6'd0,  6'd20, 6'd20};
			4'd12:   v = {6'd4,  6'd7,  6'd0};
			4'd13:   v = {6'd8,  6'd0,  6'd10};
			4'd14:   v = {6'd1,  6'd2,  6'd20};
			default: v = {6'd20, 6'd20, 6'd20};
		endcase
		return v;
	endfunction

	// group = (idx mod 9) / 3, column = (idx / 9) * 3 + idx mod 3, for idx < 27
	function automatic place_t led_place(input logic [4:0] idx);
		place_t     p;
		logic [1:0] q9;
		logic [4:0] r9;
		logic [4:0] r3;
		logic [1:0] g;
		if (idx >= 5'd18) begin
			q9 = 2'd2;
			r9 = idx - 5'd18;
		end else if (idx >= 5'd9) begin
			q9 = 2'd1;
			r9 = idx - 5'd9;
		end else begin
			q9 = 2'd0;
			r9 = idx;
		end
		if (r9 >= 5'd6) begin
			g  = 2'd2;
			r3 = r9 - 5'd6;
		end else if (r9 >= 5'd3) begin
			g  = 2'd1;
			r3 = r9 - 5'd3;
		end else begin
			g  = 2'd0;
			r3 = r9;
		end
		p.grp = g;
		p.col = 4'({q9, 1'b0}) + 4'(q9) + r3[3:0];
		return p;
	endfunction

endpackage

// ===== sv/rlm_frame_store.sv =====
// Frame store: 9 columns by 3 channel groups of red/green/blue intensities.
// Depends on rlm_pkg.
module rlm_frame_store
	import rlm_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  store_cmd_t                  cmd,
	input  logic [3:0]                  rd_col,
	output logic [NUM_GROUPS-1:0][17:0] rd_row
);

	rgb_t store_q [NUM_COLS][NUM_GROUPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_COLS; c++)
				for (int g = 0; g < NUM_GROUPS; g++)
					store_q[c][g] <= '0;
		end else if (cmd.clr) begin
			for (int c = 0; c < NUM_COLS; c++)
				for (int g = 0; g < NUM_GROUPS; g++)
					store_q[c][g] <= '0;
		end else if (cmd.wr) begin
			store_q[cmd.col][cmd.grp] <= cmd.rgb;
		end
	end

	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++)
			rd_row[g] = store_q[rd_col][g];
	end

endmodule

// ===== sv/rgb_led_matrix_pwm_refresh_core.sv =====
// Top level of the LED matrix PWM refresh core.
// Depends on rlm_pkg and rlm_frame_store.
//
// Usage:
//   Commands arrive on the s_axis stream: tick, write LED colour, clear store.
//   A write stores the palette colour of one LED; a clear zeroes the store.
//   Each tick yields one m_axis transfer with the nine channel bits of the
//   current column and a one-hot column select; writes and clears yield none.
//   cfg_we/cfg_index/cfg_data set max_level (index 0) and pwm_step (index 1);
//   write them only while the core is idle.
// Timing:
//   A command is held in an input register and executed from there, a tick only
//   once the output register is free; its result then shows from that register.
//   Unless the receiver stalls, one command per cycle is taken sustained, set by
//   the single execute stage. When the receiver stalls, the result waits in the
//   output register and one more command is held in the input register;
//   s_axis_tready then drops only if that command is a tick.
// Reset:
//   arst_n clears the store, column 0, PWM level 1, max_level 50, pwm_step 3.
module rgb_led_matrix_pwm_refresh_core
	import rlm_pkg::*;
#(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // command [1:0], led_index [6:2], color_code [10:7]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // channel_on [8:0], column_select [17:9]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data
);

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [4:0]  idx_s1;
	logic [3:0]  code_s1;

	logic [5:0]  max_level_q;
	logic [5:0]  pwm_step_q;
	logic [3:0]  col_q;
	logic [6:0]  level_q;

	logic        out_valid_q;
	logic [8:0]  out_on_q;
	logic [8:0]  out_sel_q;

	logic        is_tick;
	logic        out_free;
	logic        exec;
	logic [3:0]  col;
	logic [3:0]  col_next;
	logic [7:0]  sum;
	logic [6:0]  level_next;
	logic [8:0]  on_bits;
	logic [8:0]  sel_bits;
	place_t      place;
	store_cmd_t  store_cmd;
	logic [NUM_GROUPS-1:0][17:0] row;

	assign is_tick       = (cmd_s1 == CMD_TICK);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign exec          = valid_s1 && (!is_tick || out_free);
	assign s_axis_tready = !valid_s1 || exec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= cmd_t'(s_axis_tdata[1:0]);
			idx_s1  <= s_axis_tdata[6:2];
			code_s1 <= s_axis_tdata[10:7];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_level_q <= 6'd50;
			pwm_step_q  <= 6'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_LEVEL: max_level_q <= cfg_data;
				REG_PWM_STEP:  pwm_step_q  <= cfg_data;
				default:       max_level_q <= max_level_q;
			endcase
		end
	end

	always_comb begin
		place = led_place(idx_s1);
		store_cmd     = '0;
		store_cmd.col = place.col;
		store_cmd.grp = place.grp;
		store_cmd.rgb = palette(code_s1);
		case (cmd_s1)
			CMD_WRITE: store_cmd.wr  = exec && (idx_s1 < 5'(LED_COUNT));
			CMD_CLEAR: store_cmd.clr = exec;
			default:   store_cmd.wr  = 1'b0;
		endcase
	end

	assign col = (col_q > 4'(LAST_COL)) ? 4'd0 : col_q;

	rlm_frame_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (store_cmd),
		.rd_col (col),
		.rd_row (row)
	);

	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++)
			for (int c = 0; c < 3; c++)
				on_bits[g*3+c] = {1'b0, row[g][c*6 +: 6]} >= level_q;
		sel_bits   = 9'(1) << col;
		col_next   = (col >= 4'(LAST_COL)) ? 4'd0 : col + 4'd1;
		sum        = {1'b0, level_q} + {2'b0, pwm_step_q};
		if (sum > {2'b0, max_level_q})
			sum = sum - {2'b0, max_level_q};
		level_next = sum[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			level_q <= 7'd1;
		end else if (exec && is_tick) begin
			col_q   <= col_next;
			level_q <= level_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= exec && is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (exec && is_tick) begin
			out_on_q  <= on_bits;
			out_sel_q <= sel_bits;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_sel_q, out_on_q};

endmodule

// ===== sv/rlm_checker.sv =====
// Port-level checks for the LED matrix refresh core, bound to the top level.
// Depends on rgb_led_matrix_pwm_refresh_core_defines.svh.
`include "rgb_led_matrix_pwm_refresh_core_defines.svh"

module rlm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	`RLM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`RLM_ASSERT_NOW(a_sel_onehot, m_axis_tvalid, $onehot(m_axis_tdata[17:9]) && (m_axis_tdata[23:18] == 6'd0))
	`RLM_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind rgb_led_matrix_pwm_refresh_core rlm_checker u_rlm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
